// ----- rtl/core/wjct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worker job count table package
// Shared sizes, codes and command/status types of the worker job count table.
// ----------------------------------------------------------------------------
package wjct_pkg;

  localparam int TableDepth = 16;
  localparam int CountWidth = 16;
  localparam int IdxWidth   = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam int NameWidth  = 64;
  localparam int IpWidth    = 32;
  localparam int PortWidth  = 16;

  typedef logic [IdxWidth-1:0]          idx_t;
  typedef logic signed [CountWidth-1:0] jobs_t;

  localparam jobs_t JobsMax   = jobs_t'({1'b0, {(CountWidth-1){1'b1}}});
  localparam jobs_t JobsDeact = jobs_t'(-2);
  localparam jobs_t JobsZero  = jobs_t'(0);

  typedef enum logic [1:0] {
    CmdQuery  = 2'd0,
    CmdStart  = 2'd1,
    CmdFinish = 2'd2,
    CmdDeact  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ResOk       = 2'd0,
    ResNotFound = 2'd1,
    ResFull     = 2'd2
  } result_e;

  typedef enum logic [1:0] {
    StsNew   = 2'd0,
    StsReady = 2'd1,
    StsError = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
  } dp_cmd_t;

endpackage

// ----- rtl/core/wjct_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worker job count table channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wjct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] node_name;
  logic [31:0] node_ip;
  logic [15:0] node_port;
  logic        request_is_new;

  modport source (output valid, cmd, node_name, node_ip, node_port, request_is_new,
                  input ready);
  modport sink (input valid, cmd, node_name, node_ip, node_port, request_is_new,
                output ready);
endinterface

interface wjct_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] job_count;
  logic [1:0]         result_code;
  logic [1:0]         entry_status;
  logic [3:0]         entry_index;

  modport source (output valid, job_count, result_code, entry_status, entry_index,
                  input ready);
  modport sink (input valid, job_count, result_code, entry_status, entry_index,
                output ready);
endinterface

// ----- rtl/core/wjct_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worker job count table controller
// Sequences capture and update of one transaction and owns the output valid.
// ----------------------------------------------------------------------------
module wjct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wjct_pkg::dp_cmd_t dp_cmd_o
);

  typedef enum logic {
    StIdle,
    StUpdate
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   capture;
  logic   update;

  assign in_ready_o  = (state_q == StIdle);
  assign capture     = in_valid_i && (state_q == StIdle);
  assign update      = (state_q == StUpdate) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign dp_cmd_o    = '{capture: capture, update: update};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (capture) state_q <= StUpdate;
        end
        StUpdate: begin
          if (update) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if (update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/wjct_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worker job count table datapath
// Holds the table, matches keys in parallel and updates at most one entry per command.
// ----------------------------------------------------------------------------
module wjct_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wjct_pkg::dp_cmd_t                    dp_cmd_i,
  input  logic [1:0]                           cmd_i,
  input  logic [wjct_pkg::NameWidth-1:0]       node_name_i,
  input  logic [wjct_pkg::IpWidth-1:0]         node_ip_i,
  input  logic [wjct_pkg::PortWidth-1:0]       node_port_i,
  input  logic                                 request_is_new_i,
  output logic signed [15:0]                   job_count_o,
  output logic [1:0]                           result_code_o,
  output logic [1:0]                           entry_status_o,
  output logic [3:0]                           entry_index_o
);

  localparam int Depth = wjct_pkg::TableDepth;

  logic [Depth-1:0]                     valid_q;
  logic [wjct_pkg::NameWidth-1:0]       name_q   [Depth];
  logic [wjct_pkg::IpWidth-1:0]         ip_q     [Depth];
  logic [wjct_pkg::PortWidth-1:0]       port_q   [Depth];
  wjct_pkg::status_e                    status_q [Depth];
  wjct_pkg::jobs_t                      jobs_q   [Depth];

  wjct_pkg::cmd_e                       cmd_q;
  logic [wjct_pkg::NameWidth-1:0]       key_name_q;
  logic [wjct_pkg::IpWidth-1:0]         key_ip_q;
  logic [wjct_pkg::PortWidth-1:0]       key_port_q;
  logic                                 is_new_q;
  logic                                 hit_q, free_q;
  wjct_pkg::idx_t                       hit_idx_q, free_idx_q;

  logic                                 hit_d, free_d;
  wjct_pkg::idx_t                       hit_idx_d, free_idx_d;

  logic signed [15:0]                   job_count_q;
  wjct_pkg::result_e                    result_q;
  wjct_pkg::status_e                    res_status_q;
  logic [3:0]                           res_index_q;

  wjct_pkg::idx_t                       sel_idx;
  wjct_pkg::jobs_t                      cur_jobs, new_jobs;
  wjct_pkg::status_e                    cur_status, new_status;
  wjct_pkg::result_e                    new_result;
  logic                                 do_write, do_insert;

  // Lowest matching and lowest free slot; scanning downwards lets the lowest win.
  always_comb begin
    hit_d      = 1'b0;
    free_d     = 1'b0;
    hit_idx_d  = '0;
    free_idx_d = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (valid_q[i] && name_q[i] == node_name_i && ip_q[i] == node_ip_i &&
          port_q[i] == node_port_i) begin
        hit_d     = 1'b1;
        hit_idx_d = wjct_pkg::idx_t'(i);
      end
      if (!valid_q[i]) begin
        free_d     = 1'b1;
        free_idx_d = wjct_pkg::idx_t'(i);
      end
    end
  end

  always_comb begin
    sel_idx    = hit_q ? hit_idx_q : free_idx_q;
    cur_jobs   = hit_q ? jobs_q[sel_idx] : wjct_pkg::JobsZero;
    cur_status = hit_q ? status_q[sel_idx] : wjct_pkg::StsNew;
    new_jobs   = cur_jobs;
    new_status = cur_status;
    new_result = wjct_pkg::ResOk;
    do_write   = 1'b0;
    do_insert  = 1'b0;
    unique case (cmd_q)
      wjct_pkg::CmdStart, wjct_pkg::CmdFinish: begin
        if (!hit_q) begin
          new_result = wjct_pkg::ResNotFound;
          new_jobs   = wjct_pkg::jobs_t'(-1);
          new_status = wjct_pkg::StsNew;
        end else begin
          do_write = 1'b1;
          if (cmd_q == wjct_pkg::CmdStart) begin
            if (cur_jobs >= 0 && cur_jobs < wjct_pkg::JobsMax) begin
              new_jobs = cur_jobs + wjct_pkg::jobs_t'(1);
            end
          end else begin
            if (cur_jobs > 0) new_jobs = cur_jobs - wjct_pkg::jobs_t'(1);
          end
        end
      end
      wjct_pkg::CmdQuery, wjct_pkg::CmdDeact: begin
        if (!hit_q && !free_q) begin
          new_result = wjct_pkg::ResFull;
          new_jobs   = wjct_pkg::JobsZero;
          new_status = wjct_pkg::StsNew;
        end else begin
          do_write  = 1'b1;
          do_insert = !hit_q;
          if (cmd_q == wjct_pkg::CmdDeact) begin
            new_status = wjct_pkg::StsError;
            new_jobs   = wjct_pkg::JobsDeact;
          end else if (is_new_q && cur_status == wjct_pkg::StsError) begin
            new_status = wjct_pkg::StsReady;
            new_jobs   = wjct_pkg::JobsZero;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (dp_cmd_i.update && do_insert) begin
      valid_q[sel_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q      <= wjct_pkg::cmd_e'(cmd_i);
      key_name_q <= node_name_i;
      key_ip_q   <= node_ip_i;
      key_port_q <= node_port_i;
      is_new_q   <= request_is_new_i;
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
    end
    if (dp_cmd_i.update) begin
      if (do_write) begin
        jobs_q[sel_idx]   <= new_jobs;
        status_q[sel_idx] <= new_status;
      end
      if (do_insert) begin
        name_q[sel_idx] <= key_name_q;
        ip_q[sel_idx]   <= key_ip_q;
        port_q[sel_idx] <= key_port_q;
      end
      job_count_q  <= 16'(new_jobs);
      result_q     <= new_result;
      res_status_q <= new_status;
      res_index_q  <= (new_result == wjct_pkg::ResOk) ? 4'(sel_idx) : 4'd0;
    end
  end

  assign job_count_o    = job_count_q;
  assign result_code_o  = result_q;
  assign entry_status_o = res_status_q;
  assign entry_index_o  = res_index_q;

endmodule

// ----- rtl/core/worker_job_count_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worker job count table
// Sixteen-entry keyed table of worker nodes with status and active-job counts.
// ----------------------------------------------------------------------------
//   Channel  Role    Transaction
//   req      sink    cmd, node_name, node_ip, node_port, request_is_new
//   rsp      source  job_count, result_code, entry_status, entry_index
//
// Each transaction has two steps: the key is matched against all slots in
// parallel as it is accepted, and the entry is read, modified and written in
// the update state that follows, which also loads the response register.
// Reset clears the valid map at once; no clearing pass is needed.
// A stalled response holds the update cycle until the response register frees.
// ----------------------------------------------------------------------------
module worker_job_count_table_top (
  input logic        clk_i,
  input logic        rst_ni,
  wjct_req_if.sink   req,
  wjct_rsp_if.source rsp
);

  wjct_pkg::dp_cmd_t dp_cmd;

  wjct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .dp_cmd_o    (dp_cmd)
  );

  wjct_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dp_cmd_i         (dp_cmd),
    .cmd_i            (req.cmd),
    .node_name_i      (req.node_name),
    .node_ip_i        (req.node_ip),
    .node_port_i      (req.node_port),
    .request_is_new_i (req.request_is_new),
    .job_count_o      (rsp.job_count),
    .result_code_o    (rsp.result_code),
    .entry_status_o   (rsp.entry_status),
    .entry_index_o    (rsp.entry_index)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worker job count table testbench
// Drives commands into the worker job count table and checks every response
// against a table kept alongside in the testbench. Directed tests cover the
// job counting, the deactivation and revival of entries, exact key matching
// and long runs of job starts and finishes. Random command streams follow,
// run under several patterns of sender idling and receiver stalls, and a
// directed test of a full table ends the run.
// ----------------------------------------------------------------------------
module tb_top;
  import wjct_pkg::*;

  localparam int CycleLimit = 1_000_000;

  typedef struct {
    cmd_e        cmd;
    logic [63:0] name;
    logic [31:0] ip;
    logic [15:0] port;
    logic        is_new;
  } node_cmd_t;

  typedef struct {
    logic signed [15:0] jobs;
    result_e            code;
    status_e            status;
    logic [3:0]         slot;
  } node_reply_t;

  logic clk;
  logic rst_n;

  wjct_req_if req_ch ();
  wjct_rsp_if rsp_ch ();

  worker_job_count_table_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  logic        tbl_valid  [TableDepth];
  logic [63:0] tbl_name   [TableDepth];
  logic [31:0] tbl_ip     [TableDepth];
  logic [15:0] tbl_port   [TableDepth];
  status_e     tbl_status [TableDepth];
  jobs_t       tbl_jobs   [TableDepth];

  node_reply_t pending_replies[$];
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          err_count   = 0;
  int          cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("tb_top: mismatch at %0t ns: %s", $time, what);
    err_count++;
  endtask

  // Applies one command to the testbench copy of the table and returns the
  // response that the block should give for it.
  function automatic node_reply_t apply_cmd(input node_cmd_t c);
    node_reply_t rep;
    int          hit;
    int          j;
    hit        = -1;
    j          = 0;
    rep.code   = ResOk;
    rep.status = StsNew;
    rep.slot   = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_name[i] == c.name && tbl_ip[i] == c.ip &&
          tbl_port[i] == c.port) begin
        hit = i;
      end
    end
    if (c.cmd == CmdStart || c.cmd == CmdFinish) begin
      if (hit < 0) begin
        rep.code = ResNotFound;
        j        = -1;
      end else if (tbl_jobs[hit] >= 0) begin
        if (c.cmd == CmdStart) begin
          if (tbl_jobs[hit] != JobsMax) tbl_jobs[hit] = jobs_t'(tbl_jobs[hit] + 1);
        end else if (tbl_jobs[hit] > 0) begin
          tbl_jobs[hit] = jobs_t'(tbl_jobs[hit] - 1);
        end
      end
    end else begin
      if (hit < 0) begin
        for (int i = TableDepth - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) hit = i;
        end
        if (hit >= 0) begin
          tbl_valid[hit]  = 1'b1;
          tbl_name[hit]   = c.name;
          tbl_ip[hit]     = c.ip;
          tbl_port[hit]   = c.port;
          tbl_status[hit] = StsNew;
          tbl_jobs[hit]   = JobsZero;
        end
      end
      if (hit < 0) begin
        rep.code = ResFull;
      end else if (c.cmd == CmdQuery) begin
        if (c.is_new && tbl_status[hit] == StsError) begin
          tbl_status[hit] = StsReady;
          tbl_jobs[hit]   = JobsZero;
        end
      end else begin
        tbl_status[hit] = StsError;
        tbl_jobs[hit]   = JobsDeact;
      end
    end
    if (hit >= 0 && rep.code == ResOk) begin
      j          = int'(tbl_jobs[hit]);
      rep.status = tbl_status[hit];
      rep.slot   = 4'(hit);
    end
    if (j > 32767) j = 32767;
    if (j < -32768) j = -32768;
    rep.jobs = 16'(j);
    return rep;
  endfunction

  // Valid is left high after a transaction and only lowered when an idle
  // stretch follows, so that it is never lowered and raised in one step.
  task automatic send_cmd(input cmd_e cmd, input logic [63:0] name,
                          input logic [31:0] ip, input logic [15:0] port,
                          input logic is_new);
    node_cmd_t c;
    c = '{cmd: cmd, name: name, ip: ip, port: port, is_new: is_new};
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_ch.valid          <= 1'b1;
    req_ch.cmd            <= c.cmd;
    req_ch.node_name      <= c.name;
    req_ch.node_ip        <= c.ip;
    req_ch.node_port      <= c.port;
    req_ch.request_is_new <= c.is_new;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    pending_replies.push_back(apply_cmd(c));
  endtask

  always @(posedge clk) begin : check_rsp
    node_reply_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("response transaction with none expected");
        end else begin
          want = pending_replies.pop_front();
          if (rsp_ch.job_count !== want.jobs)
            report_mismatch($sformatf("job_count %0d, expected %0d",
                                      rsp_ch.job_count, want.jobs));
          if (rsp_ch.result_code !== want.code)
            report_mismatch($sformatf("result_code %0d, expected %0d",
                                      rsp_ch.result_code, want.code));
          if (rsp_ch.entry_status !== want.status)
            report_mismatch($sformatf("entry_status %0d, expected %0d",
                                      rsp_ch.entry_status, want.status));
          if (rsp_ch.entry_index !== want.slot)
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      rsp_ch.entry_index, want.slot));
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_job_counts();
    send_cmd(CmdQuery, '0, '0, '0, 1'b1);
    send_cmd(CmdStart, '1, '1, '1, 1'b0);
    send_cmd(CmdFinish, '1, '1, '1, 1'b1);
    send_cmd(CmdStart, '0, '0, '0, 1'b0);
    send_cmd(CmdStart, '0, '0, '0, 1'b1);
    repeat (3) send_cmd(CmdFinish, '0, '0, '0, 1'b0);
  endtask

  task automatic test_deactivate_revive();
    send_cmd(CmdDeact, '0, '0, '0, 1'b0);
    send_cmd(CmdStart, '0, '0, '0, 1'b0);
    send_cmd(CmdFinish, '0, '0, '0, 1'b0);
    send_cmd(CmdQuery, '0, '0, '0, 1'b0);
    send_cmd(CmdQuery, '0, '0, '0, 1'b1);
    send_cmd(CmdQuery, '0, '0, '0, 1'b1);
    send_cmd(CmdDeact, '1, '1, '1, 1'b1);
    send_cmd(CmdStart, '1, '1, '1, 1'b0);
  endtask

  task automatic test_key_match();
    send_cmd(CmdQuery, 64'h0000_0000_0077_3031, '0, '0, 1'b0);
    send_cmd(CmdQuery, '0, 32'h0000_0001, '0, 1'b0);
    send_cmd(CmdQuery, '0, '0, 16'h8000, 1'b0);
    send_cmd(CmdStart, 64'h8000_0000_0000_0000, '0, '0, 1'b0);
  endtask

  // A long climb of the count followed by a descent that runs into the floor.
  task automatic test_count_ramp();
    logic [63:0] nm;
    nm = 64'h0000_7361_7475_7261;
    send_cmd(CmdQuery, nm, 32'h0A00_0001, 16'd9000, 1'b0);
    repeat (200) send_cmd(CmdStart, nm, 32'h0A00_0001, 16'd9000, 1'b0);
    repeat (202) send_cmd(CmdFinish, nm, 32'h0A00_0001, 16'd9000, 1'b0);
    send_cmd(CmdDeact, nm, 32'h0A00_0001, 16'd9000, 1'b0);
  endtask

  // Most commands hit resident entries; a few use a resident key with one bit
  // flipped or an entirely fresh key, so the table fills up gradually.
  task automatic test_random(input int n_items, input int idle, input int stall);
    int          resident[$];
    int          pick;
    int          sel;
    cmd_e        cmd;
    logic [63:0] nm;
    logic [31:0] ip;
    logic [15:0] port;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n_items) begin
      resident.delete();
      foreach (tbl_valid[i]) if (tbl_valid[i]) resident.push_back(i);
      sel = $urandom_range(99);
      if (resident.size() == 0 || sel < 4) begin
        nm   = {$urandom, $urandom};
        ip   = $urandom;
        port = 16'($urandom);
      end else begin
        pick = resident[$urandom_range(resident.size() - 1)];
        nm   = tbl_name[pick];
        ip   = tbl_ip[pick];
        port = tbl_port[pick];
        if (sel < 8) begin
          case ($urandom_range(2))
            0: nm = nm ^ (64'd1 << $urandom_range(63));
            1: ip = ip ^ (32'd1 << $urandom_range(31));
            default: port = port ^ (16'd1 << $urandom_range(15));
          endcase
        end
      end
      sel = $urandom_range(99);
      if (sel < 30) cmd = CmdQuery;
      else if (sel < 60) cmd = CmdStart;
      else if (sel < 85) cmd = CmdFinish;
      else cmd = CmdDeact;
      send_cmd(cmd, nm, ip, port, 1'($urandom));
    end
  endtask

  task automatic test_table_full();
    int free_slots;
    free_slots = 0;
    foreach (tbl_valid[i]) if (!tbl_valid[i]) free_slots++;
    repeat (free_slots) send_cmd(CmdQuery, {$urandom, $urandom}, $urandom, 16'($urandom), 1'b0);
    send_cmd(CmdQuery, {$urandom, $urandom}, $urandom, 16'($urandom), 1'b1);
    send_cmd(CmdDeact, {$urandom, $urandom}, $urandom, 16'($urandom), 1'b0);
    send_cmd(CmdStart, {$urandom, $urandom}, $urandom, 16'($urandom), 1'b0);
    send_cmd(CmdFinish, {$urandom, $urandom}, $urandom, 16'($urandom), 1'b0);
  endtask

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.cmd            = CmdQuery;
    req_ch.node_name      = '0;
    req_ch.node_ip        = '0;
    req_ch.node_port      = '0;
    req_ch.request_is_new = 1'b0;
    rsp_ch.ready          = 1'b0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_job_counts();
    test_deactivate_revive();
    test_key_match();
    test_count_ramp();
    test_random(400, 0, 0);
    test_random(400, 73, 0);
    test_random(400, 0, 73);
    test_random(400, 12, 12);
    test_table_full();

    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/wjct_pkg.sv
rtl/core/wjct_if.sv
rtl/core/wjct_ctrl.sv
rtl/core/wjct_datapath.sv
rtl/core/worker_job_count_table_top.sv
sim/tb_top.sv
